>>> rtl/core/block_jump_cross_reference_top_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef BLOCK_JUMP_CROSS_REFERENCE_TOP_ASSERT_SVH
`define BLOCK_JUMP_CROSS_REFERENCE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BJXR_ASSERT_NOW(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BJXR_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error(msg);

`endif

>>> rtl/core/bjxr_pkg.sv
`default_nettype none

package bjxr_pkg;

  localparam int unsigned POS_W  = 16;
  localparam int unsigned JUMP_W = POS_W + 1;
  localparam int unsigned MAX_RES = 3;

  typedef enum logic [2:0] {
    CMD_OTHER = 3'd0,
    CMD_IF    = 3'd1,
    CMD_ELSE  = 3'd2,
    CMD_WHILE = 3'd3,
    CMD_DO    = 3'd4,
    CMD_END   = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_IF    = 2'd0,
    KIND_ELSE  = 2'd1,
    KIND_WHILE = 2'd2,
    KIND_DO    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_EMPTY_POP  = 3'd1,
    ERR_END_WHILE  = 3'd2,
    ERR_UNCLOSED   = 3'd3,
    ERR_OVERFLOW   = 3'd4
  } err_e;

  typedef enum logic {
    RES_PATCH = 1'b0,
    RES_ERROR = 1'b1
  } res_kind_e;

  typedef struct packed {
    logic [2:0]       command;
    logic [POS_W-1:0] op_position;
    logic             last_op;
  } in_req_t;

  typedef struct packed {
    logic              result_kind;
    logic [POS_W-1:0]  target_position;
    logic [JUMP_W-1:0] jump_value;
    logic [2:0]        error_code;
    logic              last_result;
  } out_res_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    kind_e            kind;
    logic [POS_W-1:0] while_position;
  } entry_t;

  typedef struct packed {
    logic   push;
    logic   pop;
    logic   clear;
    entry_t entry;
  } stack_op_t;

  typedef struct packed {
    logic [1:0]               count;
    out_res_t [MAX_RES-1:0]   res;
  } res_grp_t;

  function automatic out_res_t make_patch(input logic [POS_W-1:0]  target,
                                          input logic [JUMP_W-1:0] jump);
    out_res_t r;
    r.result_kind     = RES_PATCH;
    r.target_position = target;
    r.jump_value      = jump;
    r.error_code      = ERR_NONE;
    r.last_result     = 1'b0;
    return r;
  endfunction

  function automatic out_res_t make_error(input logic [POS_W-1:0] target,
                                          input err_e             code);
    out_res_t r;
    r.result_kind     = RES_ERROR;
    r.target_position = target;
    r.jump_value      = '0;
    r.error_code      = code;
    r.last_result     = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/bjxr_stack.sv
`default_nettype none

module bjxr_stack import bjxr_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire stack_op_t                            op_i,
  output logic [$clog2(STACK_DEPTH+1)-1:0]          depth_o,
  output entry_t                                    top_o,
  output entry_t                                    below_o
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  // The top entry and the one below it live in registers; deeper entries
  // live in the memory, so every push or pop touches at most one port.
  entry_t        mem [STACK_DEPTH];
  entry_t        top_q;
  entry_t        below_q;
  logic [CW-1:0] depth_q;
  logic [CW-1:0] depth_d;
  logic [CW-1:0] wr_full;
  logic [CW-1:0] rd_full;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic          push_only;
  logic          pop_only;

  assign push_only = op_i.push && !op_i.pop;
  assign pop_only  = op_i.pop && !op_i.push;
  assign wr_full   = depth_q - CW'(1);
  assign rd_full   = depth_q - CW'(3);
  assign wr_addr   = wr_full[AW-1:0];
  assign rd_addr   = rd_full[AW-1:0];

  always_comb begin
    depth_d = depth_q;
    if (op_i.clear) begin
      depth_d = '0;
    end else if (push_only) begin
      depth_d = depth_q + CW'(1);
    end else if (pop_only) begin
      depth_d = depth_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
    end else begin
      depth_q <= depth_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_only) begin
      top_q   <= op_i.entry;
      below_q <= top_q;
      if (depth_q != '0) begin
        mem[wr_addr] <= top_q;
      end
    end else if (pop_only) begin
      top_q <= below_q;
      if (depth_q > CW'(2)) begin
        below_q <= mem[rd_addr];
      end
    end else if (op_i.push) begin
      top_q <= op_i.entry;
    end
  end

  assign depth_o = depth_q;
  assign top_o   = top_q;
  assign below_o = below_q;

endmodule

`default_nettype wire

>>> rtl/core/bjxr_emit.sv
`default_nettype none

module bjxr_emit import bjxr_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     load_i,
  input  wire res_grp_t grp_i,
  output logic          free_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output out_res_t      out_res_o
);

  out_res_t [MAX_RES-1:0] res_q;
  logic [1:0]             cnt_q;
  logic [1:0]             cnt_d;
  logic                   take;

  assign take   = (cnt_q != 2'd0) && out_ready_i;
  assign free_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);

  always_comb begin
    cnt_d = cnt_q;
    if (load_i) begin
      cnt_d = grp_i.count;
    end else if (take) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= grp_i.res;
    end else if (take) begin
      res_q[0] <= res_q[1];
      res_q[1] <= res_q[2];
    end
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_res_o   = res_q[0];

endmodule

`default_nettype wire

>>> rtl/core/block_jump_cross_reference_top.sv
`default_nettype none

// Pairs block openers with their closers for a stream of program ops and
// emits operand patches, or one error report after which the block ignores
// all further ops until reset. An accepted op waits in an input register and
// is resolved against the two top stack entries, which are held in registers
// over a single-port stack memory of STACK_DEPTH entries; its results are
// then drained from a result buffer one per cycle while the receiver is
// ready. An op is resolved only when the buffer is empty or its last
// result is being taken, so ops with at most one result go at one op per
// cycle while the receiver is ready. No clearing pass is needed after reset.
module block_jump_cross_reference_top import bjxr_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_req_t  in_req_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output out_res_t      out_res_o
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  in_req_t          in_q;
  logic             in_vld_q;
  logic             halted_q;
  logic             fire;
  logic             free;
  logic             err_hit;
  logic [1:0]       n_res;
  logic [CW-1:0]    depth;
  logic [CW-1:0]    depth_after;
  logic [POS_W-1:0] blame;
  logic [JUMP_W-1:0] pos_inc;
  logic             empty;
  logic             full;
  entry_t           top;
  entry_t           below;
  stack_op_t        sop;
  stack_op_t        sop_gated;
  res_grp_t         grp;

  assign fire       = in_vld_q && free;
  assign in_ready_o = !in_vld_q || fire;
  assign empty      = (depth == '0);
  assign full       = (depth == CW'(STACK_DEPTH));
  assign pos_inc    = {1'b0, in_q.op_position} + JUMP_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      halted_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_vld_q <= 1'b1;
      end else if (fire) begin
        in_vld_q <= 1'b0;
      end
      if (fire && err_hit) begin
        halted_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_req_i;
    end
  end

  always_comb begin
    grp         = '0;
    sop         = '0;
    err_hit     = 1'b0;
    n_res       = 2'd0;
    depth_after = depth;
    blame       = top.position;
    if (!halted_q) begin
      unique case (in_q.command)
        CMD_IF, CMD_WHILE: begin
          if (full) begin
            grp.res[0] = make_error(in_q.op_position, ERR_OVERFLOW);
            n_res      = 2'd1;
            err_hit    = 1'b1;
          end else begin
            sop.push                 = 1'b1;
            sop.entry.position       = in_q.op_position;
            sop.entry.kind           = (in_q.command == CMD_IF) ? KIND_IF : KIND_WHILE;
            sop.entry.while_position = '0;
          end
        end
        CMD_ELSE, CMD_DO, CMD_END: begin
          if (empty) begin
            grp.res[0] = make_error(in_q.op_position, ERR_EMPTY_POP);
            n_res      = 2'd1;
            err_hit    = 1'b1;
          end else if (in_q.command == CMD_ELSE) begin
            grp.res[0]               = make_patch(top.position, pos_inc);
            n_res                    = 2'd1;
            sop.push                 = 1'b1;
            sop.pop                  = 1'b1;
            sop.entry.position       = in_q.op_position;
            sop.entry.kind           = KIND_ELSE;
            sop.entry.while_position = '0;
          end else if (in_q.command == CMD_DO) begin
            grp.res[0]               = make_patch(in_q.op_position, {1'b0, top.position});
            n_res                    = 2'd1;
            sop.push                 = 1'b1;
            sop.pop                  = 1'b1;
            sop.entry.position       = in_q.op_position;
            sop.entry.kind           = KIND_DO;
            sop.entry.while_position = top.position;
          end else begin
            unique case (top.kind)
              KIND_IF, KIND_ELSE: begin
                grp.res[0] = make_patch(top.position, {1'b0, in_q.op_position});
                grp.res[1] = make_patch(in_q.op_position, pos_inc);
                n_res      = 2'd2;
                sop.pop    = 1'b1;
              end
              KIND_DO: begin
                grp.res[0] = make_patch(top.position, pos_inc);
                grp.res[1] = make_patch(in_q.op_position, {1'b0, top.while_position});
                n_res      = 2'd2;
                sop.pop    = 1'b1;
              end
              default: begin
                grp.res[0] = make_error(top.position, ERR_END_WHILE);
                n_res      = 2'd1;
                err_hit    = 1'b1;
              end
            endcase
          end
        end
        default: begin
        end
      endcase

      if (sop.push && !sop.pop) begin
        depth_after = depth + CW'(1);
      end else if (sop.pop && !sop.push) begin
        depth_after = depth - CW'(1);
      end
      if (sop.push) begin
        blame = in_q.op_position;
      end else if (sop.pop) begin
        blame = below.position;
      end

      if (in_q.last_op && !err_hit) begin
        sop.clear = 1'b1;
        if (depth_after != '0) begin
          grp.res[n_res] = make_error(blame, ERR_UNCLOSED);
          n_res          = n_res + 2'd1;
          err_hit        = 1'b1;
        end
      end
    end
    if (n_res != 2'd0) begin
      grp.res[n_res - 2'd1].last_result = 1'b1;
    end
    grp.count = n_res;
  end

  assign sop_gated = fire ? sop : '0;

  bjxr_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_i    (sop_gated),
    .depth_o (depth),
    .top_o   (top),
    .below_o (below)
  );

  bjxr_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .grp_i       (grp),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/bjxr_checker.sv
`default_nettype none

`include "block_jump_cross_reference_top_assert.svh"

module bjxr_checker import bjxr_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_ready_o,
  input wire in_req_t  in_req_i,
  input wire logic     out_valid_o,
  input wire logic     out_ready_i,
  input wire out_res_t out_res_o
);

  logic err_taken;
  logic unused_in;

  assign err_taken = out_valid_o && out_ready_i && (out_res_o.result_kind == RES_ERROR);
  assign unused_in = in_valid_i ^ (^in_req_i);

  `BJXR_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_res_o), "Stalled result changed.")
  `BJXR_ASSERT_NOW(a_err_last, out_valid_o && (out_res_o.result_kind == RES_ERROR), out_res_o.last_result && (out_res_o.jump_value == '0), "Error result is not the last result of its request.")
  `BJXR_ASSERT_NOW(a_patch_code, out_valid_o && (out_res_o.result_kind == RES_PATCH), out_res_o.error_code == ERR_NONE, "Patch result carries an error code.")
  `BJXR_ASSERT_NEXT(a_halt_quiet, err_taken, !out_valid_o && in_ready_o, "Block did not halt quietly after an error.")

endmodule

bind block_jump_cross_reference_top bjxr_checker u_bjxr_checker (.*);

`default_nettype wire

>>> tb/sv/tb_block_jump_cross_reference_top.sv
`timescale 1ns / 100ps

module tb_block_jump_cross_reference_top;
  import bjxr_pkg::*;

  localparam int unsigned STACK_DEPTH   = 64;
  localparam int unsigned ITEM_GOAL     = 310;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned TABLE_ROWS    = 21;
  localparam logic [2:0]  CMD_SPARE_LO  = 3'd6;
  localparam logic [2:0]  CMD_SPARE_HI  = 3'd7;

  typedef enum int unsigned {
    FAULT_EMPTY_POP,
    FAULT_END_WHILE,
    FAULT_UNCLOSED,
    FAULT_OVERFLOW
  } fault_e;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [POS_W-1:0]  pos;
    logic              last;
    logic [1:0]        n_fixed;
    logic [POS_W-1:0]  target0;
    logic [JUMP_W-1:0] jump0;
    logic [POS_W-1:0]  target1;
    logic [JUMP_W-1:0] jump1;
  } op_row_t;

  localparam op_row_t OP_TABLE [TABLE_ROWS] = '{
    '{CMD_OTHER,    16'h0000, 1'b0, 2'd0, 16'h0000, 17'h00000, 16'h0000, 17'h00000},
    '{CMD_IF,       16'h0000, 1'b0, 2'd0, 16'h0000, 17'h00000, 16'h0000, 17'h00000},
    '{CMD_ELSE,     16'hFFFF, 1'b0, 2'd1, 16'h0000, 17'h10000, 16'h0000, 17'h00000},
    '{CMD_END,      16'h1234, 1'b0, 2'd2, 16'hFFFF, 17'h01234, 16'h1234, 17'h01235},
    '{CMD_WHILE,    16'hFFFF, 1'b0, 2'd0, 16'h0000, 17'h00000, 16'h0000, 17'h00000},
    '{CMD_DO,       16'h0000, 1'b0, 2'd1, 16'h0000, 17'h0FFFF, 16'h0000, 17'h00000},
    '{CMD_END,      16'hFFFF, 1'b0, 2'd2, 16'h0000, 17'h10000, 16'hFFFF, 17'h0FFFF},
    '{CMD_WHILE,    16'h8000, 1'b0, 2'd0, 16'h0000, 17'h00000, 16'h0000, 17'h00000},
    '{CMD_ELSE,     16'h7FFF, 1'b0, 2'd1, 16'h8000, 17'h08000, 16'h0000, 17'h00000},
    '{CMD_DO,       16'h5555, 1'b0, 2'd1, 16'h5555, 17'h07FFF, 16'h0000, 17'h00000},
    '{CMD_ELSE,     16'hAAAA, 1'b0, 2'd1, 16'h5555, 17'h0AAAB, 16'h0000, 17'h00000},
    '{CMD_END,      16'h0001, 1'b1, 2'd2, 16'hAAAA, 17'h00001, 16'h0001, 17'h00002},
    '{CMD_IF,       16'h00FF, 1'b0, 2'd0, 16'h0000, 17'h00000, 16'h0000, 17'h00000},
    '{CMD_DO,       16'hFF00, 1'b0, 2'd1, 16'hFF00, 17'h000FF, 16'h0000, 17'h00000},
    '{CMD_SPARE_HI, 16'h1111, 1'b0, 2'd0, 16'h0000, 17'h00000, 16'h0000, 17'h00000},
    '{CMD_END,      16'hFFFF, 1'b0, 2'd2, 16'hFF00, 17'h10000, 16'hFFFF, 17'h000FF},
    '{CMD_SPARE_LO, 16'hFFFF, 1'b1, 2'd0, 16'h0000, 17'h00000, 16'h0000, 17'h00000},
    '{CMD_IF,       16'h0002, 1'b0, 2'd0, 16'h0000, 17'h00000, 16'h0000, 17'h00000},
    '{CMD_IF,       16'h0003, 1'b0, 2'd0, 16'h0000, 17'h00000, 16'h0000, 17'h00000},
    '{CMD_END,      16'h0004, 1'b0, 2'd2, 16'h0003, 17'h00004, 16'h0004, 17'h00005},
    '{CMD_END,      16'h0005, 1'b1, 2'd2, 16'h0002, 17'h00005, 16'h0005, 17'h00006}
  };

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  in_req_t  in_req    = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_res_t out_res;

  entry_t      open_blocks [STACK_DEPTH];
  int unsigned open_depth = 0;
  bit          is_halted  = 1'b0;
  out_res_t    op_results [$];
  out_res_t    awaited [$];
  out_res_t    oldest;

  int unsigned mismatches   = 0;
  int unsigned ops_sent     = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left   = 0;
  int unsigned recv_cycle   = 0;
  bit          sender_calm  = 1'b0;
  bit          recv_calm    = 1'b0;

  block_jump_cross_reference_top #(.STACK_DEPTH(STACK_DEPTH)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_res_o   (out_res)
  );

  always #6 clk_i = ~clk_i;

  function automatic out_res_t patch_of(input logic [POS_W-1:0] target,
                                        input logic [JUMP_W-1:0] jump);
    out_res_t r;
    r.result_kind     = RES_PATCH;
    r.target_position = target;
    r.jump_value      = jump;
    r.error_code      = ERR_NONE;
    r.last_result     = 1'b0;
    return r;
  endfunction

  function automatic void raise_fault(input logic [POS_W-1:0] target, input err_e code);
    out_res_t r;
    r.result_kind     = RES_ERROR;
    r.target_position = target;
    r.jump_value      = '0;
    r.error_code      = code;
    r.last_result     = 1'b0;
    op_results.push_back(r);
    is_halted = 1'b1;
  endfunction

  function automatic void push_block(input logic [POS_W-1:0] pos, input kind_e kind,
                                     input logic [POS_W-1:0] while_pos);
    open_blocks[open_depth].position       = pos;
    open_blocks[open_depth].kind           = kind;
    open_blocks[open_depth].while_position = while_pos;
    open_depth++;
  endfunction

  function automatic void resolve_op(input in_req_t r);
    entry_t            top;
    logic [JUMP_W-1:0] next_pos;
    out_res_t          tail;
    op_results.delete();
    if (is_halted) return;
    next_pos = {1'b0, r.op_position} + 1'b1;
    case (r.command)
      CMD_IF, CMD_WHILE: begin
        if (open_depth == STACK_DEPTH) raise_fault(r.op_position, ERR_OVERFLOW);
        else push_block(r.op_position, (r.command == CMD_IF) ? KIND_IF : KIND_WHILE, '0);
      end
      CMD_ELSE, CMD_DO, CMD_END: begin
        if (open_depth == 0) begin
          raise_fault(r.op_position, ERR_EMPTY_POP);
        end else begin
          open_depth--;
          top = open_blocks[open_depth];
          if (r.command == CMD_ELSE) begin
            op_results.push_back(patch_of(top.position, next_pos));
            push_block(r.op_position, KIND_ELSE, '0);
          end else if (r.command == CMD_DO) begin
            op_results.push_back(patch_of(r.op_position, {1'b0, top.position}));
            push_block(r.op_position, KIND_DO, top.position);
          end else if (top.kind == KIND_WHILE) begin
            raise_fault(top.position, ERR_END_WHILE);
          end else if (top.kind == KIND_DO) begin
            op_results.push_back(patch_of(top.position, next_pos));
            op_results.push_back(patch_of(r.op_position, {1'b0, top.while_position}));
          end else begin
            op_results.push_back(patch_of(top.position, {1'b0, r.op_position}));
            op_results.push_back(patch_of(r.op_position, next_pos));
          end
        end
      end
      default: ;
    endcase
    if (!is_halted && r.last_op) begin
      if (open_depth > 0) raise_fault(open_blocks[open_depth-1].position, ERR_UNCLOSED);
      open_depth = 0;
    end
    if (op_results.size() > 0) begin
      tail = op_results.pop_back();
      tail.last_result = 1'b1;
      op_results.push_back(tail);
    end
  endfunction

  function automatic in_req_t make_req(input logic [2:0] cmd, input logic [POS_W-1:0] pos,
                                       input logic last);
    in_req_t r;
    r.command     = cmd;
    r.op_position = pos;
    r.last_op     = last;
    return r;
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return POS_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [2:0] pick_noise();
    case ($urandom_range(0, 2))
      0:       return CMD_OTHER;
      1:       return CMD_SPARE_LO;
      default: return CMD_SPARE_HI;
    endcase
  endfunction

  function automatic logic [2:0] pick_opener();
    return $urandom_range(0, 1) ? CMD_IF : CMD_WHILE;
  endfunction

  function automatic logic [2:0] pick_closer();
    case ($urandom_range(0, 2))
      0:       return CMD_ELSE;
      1:       return CMD_DO;
      default: return CMD_END;
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (sender_calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic issue_op(input in_req_t r, input logic [1:0] n_fixed = '0,
                          input out_res_t fixed0 = '0, input out_res_t fixed1 = '0);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    if (r.command inside {[CMD_IF:CMD_END]}) ops_sent++;
    resolve_op(r);
    if (n_fixed == 0) begin
      foreach (op_results[i]) awaited.push_back(op_results[i]);
    end else begin
      awaited.push_back(fixed0);
      if (n_fixed > 1) awaited.push_back(fixed1);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (awaited.size() != 0);
  endtask

  task automatic run_program(input bit to_full);
    int unsigned body_len;
    int unsigned push_pct;
    logic [2:0]  cmd;
    bit          closed;
    body_len    = 0;
    push_pct    = 0;
    sender_calm = ($urandom_range(0, 3) == 0);
    if (to_full) begin
      while (open_depth < STACK_DEPTH) issue_op(make_req(pick_opener(), pick_pos(), 1'b0));
    end else if ($urandom_range(0, 7) == 0) begin
      body_len = $urandom_range(30, 90);
      push_pct = 75;
    end else begin
      body_len = $urandom_range(1, 14);
      push_pct = $urandom_range(30, 55);
    end
    repeat (body_len) begin
      if ($urandom_range(0, 99) < 8) begin
        cmd = pick_noise();
      end else if (open_depth == 0 ||
                   (open_depth < STACK_DEPTH && $urandom_range(0, 99) < push_pct)) begin
        cmd = pick_opener();
      end else begin
        cmd = pick_closer();
        if (cmd == CMD_END && open_blocks[open_depth-1].kind == KIND_WHILE) cmd = CMD_DO;
      end
      issue_op(make_req(cmd, pick_pos(), 1'b0));
    end
    closed = 1'b0;
    while (open_depth > 0) begin
      if (open_blocks[open_depth-1].kind == KIND_WHILE) begin
        cmd = $urandom_range(0, 1) ? CMD_DO : CMD_ELSE;
      end else begin
        cmd = CMD_END;
      end
      closed = (cmd == CMD_END && open_depth == 1);
      issue_op(make_req(cmd, pick_pos(), closed));
    end
    if (!closed) issue_op(make_req(pick_noise(), pick_pos(), 1'b1));
  endtask

  task automatic provoke_fault(input fault_e fault);
    logic [2:0] cmd;
    case (fault)
      FAULT_EMPTY_POP: begin
        issue_op(make_req(pick_closer(), pick_pos(), 1'($urandom_range(0, 1))));
      end
      FAULT_END_WHILE: begin
        repeat ($urandom_range(0, 2)) issue_op(make_req(CMD_IF, pick_pos(), 1'b0));
        issue_op(make_req(CMD_WHILE, pick_pos(), 1'b0));
        issue_op(make_req(CMD_END, pick_pos(), 1'($urandom_range(0, 1))));
      end
      FAULT_UNCLOSED: begin
        issue_op(make_req(pick_opener(), pick_pos(), 1'b0));
        issue_op(make_req(CMD_IF, pick_pos(), 1'b0));
        case ($urandom_range(0, 2))
          0:       cmd = CMD_END;
          1:       cmd = CMD_WHILE;
          default: cmd = CMD_ELSE;
        endcase
        issue_op(make_req(cmd, pick_pos(), 1'b1));
      end
      default: begin
        while (open_depth < STACK_DEPTH) issue_op(make_req(pick_opener(), pick_pos(), 1'b0));
        issue_op(make_req(pick_opener(), pick_pos(), 1'($urandom_range(0, 1))));
      end
    endcase
  endtask

  task automatic note_mismatch(input string what, input out_res_t want, input out_res_t got);
    if (mismatches < 10) begin
      $display("%s at %0t: expected kind %0d target %h jump %h code %0d last %0d",
               what, $time, want.result_kind, want.target_position, want.jump_value,
               want.error_code, want.last_result);
      $display("  got kind %0d target %h jump %h code %0d last %0d",
               got.result_kind, got.target_position, got.jump_value,
               got.error_code, got.last_result);
    end
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    recv_cycle++;
    if (recv_cycle % 256 == 0) recv_calm = ($urandom_range(0, 3) == 0);
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (!recv_calm && $urandom_range(0, 99) < 25) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (awaited.size() == 0) begin
        note_mismatch("Result with nothing awaited", '0, out_res);
      end else begin
        oldest = awaited.pop_front();
        if (out_res.result_kind !== oldest.result_kind ||
            out_res.target_position !== oldest.target_position ||
            out_res.jump_value !== oldest.jump_value ||
            out_res.error_code !== oldest.error_code ||
            out_res.last_result !== oldest.last_result) begin
          note_mismatch("Result mismatch", oldest, out_res);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    out_res_t fixed0;
    out_res_t fixed1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < TABLE_ROWS; i++) begin
      fixed0 = patch_of(OP_TABLE[i].target0, OP_TABLE[i].jump0);
      fixed1 = patch_of(OP_TABLE[i].target1, OP_TABLE[i].jump1);
      if (OP_TABLE[i].n_fixed == 2'd1) fixed0.last_result = 1'b1;
      else fixed1.last_result = 1'b1;
      issue_op(make_req(OP_TABLE[i].cmd, OP_TABLE[i].pos, OP_TABLE[i].last),
               OP_TABLE[i].n_fixed, fixed0, fixed1);
    end
    run_program(1'b1);
    while (ops_sent < ITEM_GOAL) begin
      if ($urandom_range(0, 5) == 0) drain_results();
      run_program(1'b0);
    end
    drain_results();
    sender_calm = 1'b0;
    provoke_fault(fault_e'($urandom_range(0, 3)));
    repeat (8) begin
      issue_op(make_req(3'($urandom_range(0, 7)), pick_pos(), 1'($urandom_range(0, 1))));
    end
    in_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && awaited.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/bjxr_pkg.sv
rtl/core/bjxr_stack.sv
rtl/core/bjxr_emit.sv
rtl/core/block_jump_cross_reference_top.sv
rtl/core/bjxr_checker.sv
tb/sv/tb_block_jump_cross_reference_top.sv
